@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files of the key escape decoder.
// Each macro checks one property on the rising edge of clock, with reset masking it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An immediate-style check of a condition on every clock edge out of reset.
`define CHECK_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("check failed: condition does not hold");

// An implication checked on every clock edge out of reset.
`define CHECK_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: implication does not hold");

// A next-cycle implication checked on every clock edge out of reset.
`define CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication does not hold");

`endif

@@ sv/vtkd_pkg.sv @@
package vtkd_pkg;

   // Decoder modes of the escape-sequence state machine.
   typedef enum logic [3:0] {
      MODE_GROUND  = 4'd0,
      MODE_ESC     = 4'd1,
      MODE_SS2     = 4'd2,
      MODE_SS3     = 4'd3,
      MODE_DCS     = 4'd4,
      MODE_CSI_PAR = 4'd5,
      MODE_CSI_INT = 4'd6,
      MODE_CSI_FIN = 4'd7,
      MODE_ST      = 4'd8,
      MODE_OSC     = 4'd9,
      MODE_SOS     = 4'd10,
      MODE_PM      = 4'd11,
      MODE_APC     = 4'd12
   } mode_type;

   // Key codes reported in key_kind.
   localparam logic [3:0] KEY_BACK   = 4'd0;
   localparam logic [3:0] KEY_RETURN = 4'd1;
   localparam logic [3:0] KEY_ESCAPE = 4'd2;
   localparam logic [3:0] KEY_DELETE = 4'd3;
   localparam logic [3:0] KEY_UP     = 4'd4;
   localparam logic [3:0] KEY_DOWN   = 4'd5;
   localparam logic [3:0] KEY_RIGHT  = 4'd6;
   localparam logic [3:0] KEY_LEFT   = 4'd7;
   localparam logic [3:0] KEY_HOME   = 4'd8;
   localparam logic [3:0] KEY_END    = 4'd9;
   localparam logic [3:0] KEY_PGUP   = 4'd10;
   localparam logic [3:0] KEY_PGDN   = 4'd11;

   // Byte values of the terminal protocol.
   localparam logic [7:0] BYTE_BS        = 8'h08;
   localparam logic [7:0] BYTE_CR        = 8'h0d;
   localparam logic [7:0] BYTE_ESC       = 8'h1b;
   localparam logic [7:0] BYTE_DEL       = 8'h7f;
   localparam logic [7:0] BYTE_PAR_LO    = 8'h30;
   localparam logic [7:0] BYTE_PAR_HI    = 8'h3f;
   localparam logic [7:0] BYTE_INT_LO    = 8'h20;
   localparam logic [7:0] BYTE_INT_HI    = 8'h2f;
   localparam logic [7:0] BYTE_CHAR_N    = 8'h4e;
   localparam logic [7:0] BYTE_CHAR_O    = 8'h4f;
   localparam logic [7:0] BYTE_CHAR_P    = 8'h50;
   localparam logic [7:0] BYTE_CHAR_X    = 8'h58;
   localparam logic [7:0] BYTE_LBRACKET  = 8'h5b;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
   localparam logic [7:0] BYTE_RBRACKET  = 8'h5d;
   localparam logic [7:0] BYTE_CARET     = 8'h5e;
   localparam logic [7:0] BYTE_UNDERLINE = 8'h5f;
   localparam logic [7:0] BYTE_CHAR_A    = 8'h41;
   localparam logic [7:0] BYTE_CHAR_B    = 8'h42;
   localparam logic [7:0] BYTE_CHAR_C    = 8'h43;
   localparam logic [7:0] BYTE_CHAR_D    = 8'h44;
   localparam logic [7:0] BYTE_TILDE     = 8'h7e;
   localparam logic [7:0] BYTE_DIGIT_1   = 8'h31;
   localparam logic [7:0] BYTE_DIGIT_4   = 8'h34;
   localparam logic [7:0] BYTE_DIGIT_5   = 8'h35;
   localparam logic [7:0] BYTE_DIGIT_6   = 8'h36;

   // One decoded key or character.
   typedef struct packed {
      logic       is_key;
      logic [3:0] key_kind;
      logic [7:0] char_code;
   } key_result_type;

   // Decoder output toward the result register.
   typedef struct packed {
      logic           emit;
      key_result_type result;
   } decode_out_type;

endpackage

@@ sv/vtkd_in_reg.sv @@
module vtkd_in_reg
   import vtkd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // The register frees up whenever its byte moves on to the decoder.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register loads on every accepted transaction.
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

@@ sv/vtkd_decode.sv @@
`include "assert_macros.svh"

module vtkd_decode
   import vtkd_pkg::*;
#(
   parameter int PARAM_CAPACITY = 32
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     byte_data,
   output decode_out_type dec_out
);

   localparam int LEN_W = $clog2(PARAM_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PARAM_CAPACITY - 1);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   mode_type         mode_ff;
   mode_type         mode_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [7:0]       first_ff;
   logic [7:0]       first_in;
   logic             found;
   key_result_type   res;
   logic             go_int;
   logic             go_fin;

   // State register; it moves only when a byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_GROUND;
         len_ff   <= '0;
         first_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         first_ff <= first_in;
      end
   end

   // Next mode and key.  A byte that closes the parameter or intermediate
   // phase falls through into the following phase in the same cycle.
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      first_in = first_ff;
      found    = 1'b0;
      res      = '0;
      go_int   = 1'b0;
      go_fin   = 1'b0;
      case (mode_ff)
         MODE_GROUND: begin
            if (byte_data == BYTE_BS) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_BACK;
            end else if (byte_data == BYTE_CR) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_RETURN;
            end else if (byte_data == BYTE_ESC) begin
               mode_in = MODE_ESC;
            end else if (byte_data == BYTE_DEL) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_DELETE;
            end else begin
               found         = 1'b1;
               res.char_code = byte_data;
            end
         end
         MODE_ESC: begin
            case (byte_data)
               BYTE_ESC: begin
                  found        = 1'b1;
                  res.is_key   = 1'b1;
                  res.key_kind = KEY_ESCAPE;
                  mode_in      = MODE_GROUND;
               end
               BYTE_CHAR_N:    mode_in = MODE_SS2;
               BYTE_CHAR_O:    mode_in = MODE_SS3;
               BYTE_CHAR_P:    mode_in = MODE_DCS;
               BYTE_LBRACKET: begin
                  len_in  = '0;
                  mode_in = MODE_CSI_PAR;
               end
               BYTE_BACKSLASH: mode_in = MODE_ST;
               BYTE_RBRACKET:  mode_in = MODE_OSC;
               BYTE_CHAR_X:    mode_in = MODE_SOS;
               BYTE_CARET:     mode_in = MODE_PM;
               BYTE_UNDERLINE: mode_in = MODE_APC;
               default:        mode_in = MODE_GROUND;
            endcase
         end
         MODE_CSI_PAR: begin
            if (byte_data >= BYTE_PAR_LO && byte_data <= BYTE_PAR_HI) begin
               if (len_ff < LEN_MAX) begin
                  if (len_ff == '0) begin
                     first_in = byte_data;
                  end
                  len_in = len_ff + LEN_ONE;
               end
            end else begin
               go_int = 1'b1;
            end
         end
         MODE_CSI_INT: go_int = 1'b1;
         MODE_CSI_FIN: go_fin = 1'b1;
         default:      mode_in = MODE_GROUND;
      endcase

      // Intermediate bytes are skipped; anything else is the final byte.
      if (go_int) begin
         if (byte_data >= BYTE_INT_LO && byte_data <= BYTE_INT_HI) begin
            mode_in = MODE_CSI_INT;
         end else begin
            go_fin = 1'b1;
         end
      end

      // Final byte of a control sequence: arrows or tilde keys.
      if (go_fin) begin
         mode_in = MODE_GROUND;
         if (byte_data == BYTE_CHAR_A) begin
            found        = 1'b1;
            res.is_key   = 1'b1;
            res.key_kind = KEY_UP;
         end else if (byte_data == BYTE_CHAR_B) begin
            found        = 1'b1;
            res.is_key   = 1'b1;
            res.key_kind = KEY_DOWN;
         end else if (byte_data == BYTE_CHAR_C) begin
            found        = 1'b1;
            res.is_key   = 1'b1;
            res.key_kind = KEY_RIGHT;
         end else if (byte_data == BYTE_CHAR_D) begin
            found        = 1'b1;
            res.is_key   = 1'b1;
            res.key_kind = KEY_LEFT;
         end else if (byte_data == BYTE_TILDE && len_ff == LEN_ONE) begin
            if (first_ff == BYTE_DIGIT_1) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_HOME;
            end else if (first_ff == BYTE_DIGIT_4) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_END;
            end else if (first_ff == BYTE_DIGIT_5) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_PGUP;
            end else if (first_ff == BYTE_DIGIT_6) begin
               found        = 1'b1;
               res.is_key   = 1'b1;
               res.key_kind = KEY_PGDN;
            end
         end
      end
   end

   assign dec_out.emit   = advance && found;
   assign dec_out.result = res;

   // The parameter count saturates below the capacity.
   `CHECK_ALWAYS(a_len_saturates, len_ff <= LEN_MAX)
   // The final phase is always resolved in the same cycle, so it is never stored.
   `CHECK_ALWAYS(a_no_stored_final, mode_ff != MODE_CSI_FIN)
   // A key leaves the character field clear, a character leaves the key field clear.
   `CHECK_IMPLIES(a_key_fields, dec_out.emit && dec_out.result.is_key,
      dec_out.result.char_code == '0)
   `CHECK_IMPLIES(a_char_fields, dec_out.emit && !dec_out.result.is_key,
      dec_out.result.key_kind == '0)
   // A control sequence always starts with a cleared parameter count.
   `CHECK_NEXT(a_csi_clears, advance && mode_ff == MODE_ESC && byte_data == BYTE_LBRACKET,
      len_ff == '0)

endmodule

@@ sv/vtkd_out_reg.sv @@
module vtkd_out_reg
   import vtkd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  decode_out_type dec_out,
   output logic           out_busy,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_is_key,
   output logic [3:0]     rsp_key_kind,
   output logic [7:0]     rsp_char_code
);

   logic           valid_ff;
   logic           valid_in;
   key_result_type result_ff;

   // The register holds a result until the transaction completes.
   assign out_busy = valid_ff && !rsp_ready;
   assign valid_in = dec_out.emit || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_out.emit) begin
         result_ff <= dec_out.result;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_is_key    = result_ff.is_key;
   assign rsp_key_kind  = result_ff.key_kind;
   assign rsp_char_code = result_ff.char_code;

endmodule

@@ sv/vt100_key_escape_decoder.sv @@
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// request   | req_valid, req_ready, req_rx_byte            | in
// response  | rsp_valid, rsp_ready, rsp_is_key,            | out
//           | rsp_key_kind, rsp_char_code                  |
//
// One byte per cycle while the response is not stalled: a byte is decoded while it
// sits in the input register, and its key or character, if any, is loaded into the
// result register at the next clock edge. The state update is combinational logic
// between the input register and the result register.
// Synchronous reset puts the decoder in ground state with an empty parameter.
// A stalled response holds the decoder; the input register still takes one byte.

`include "assert_macros.svh"

module vt100_key_escape_decoder
   import vtkd_pkg::*;
#(
   parameter int PARAM_CAPACITY = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_key,
   output logic [3:0] rsp_key_kind,
   output logic [7:0] rsp_char_code
);

   logic           byte_valid;
   logic [7:0]     byte_data;
   logic           advance;
   logic           out_busy;
   decode_out_type dec_out;

   // A byte is decoded when the result register can take whatever it yields.
   assign advance = byte_valid && !out_busy;

   vtkd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   vtkd_decode #(
      .PARAM_CAPACITY (PARAM_CAPACITY)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .dec_out   (dec_out)
   );

   vtkd_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .dec_out       (dec_out),
      .out_busy      (out_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_key    (rsp_is_key),
      .rsp_key_kind  (rsp_key_kind),
      .rsp_char_code (rsp_char_code)
   );

   // A new result is never produced over one that is still stalled.
   `CHECK_IMPLIES(a_no_overwrite, rsp_valid && !rsp_ready, !dec_out.emit)
   // A pending byte with a free result register is always decoded.
   `CHECK_IMPLIES(a_no_idle, byte_valid && !rsp_valid, advance)
   // A decoded key shows up on the response port in the next cycle.
   `CHECK_NEXT(a_emit_shows, dec_out.emit, rsp_valid)

endmodule
